// ===== hw/rtl/mcsmf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the maze cell stack with minimum finder.
// No dependencies; used by every file of the block.
package mcsmf_pkg;

   localparam int MAZE_SIDE_DEFAULT   = 16;
   localparam int STACK_DEPTH_DEFAULT = 64;

   localparam int COORD_W    = 4;             // pos_x / pos_y width
   localparam int COORD_SPAN = 1 << COORD_W;  // largest usable maze side
   localparam int VALUE_W    = 8;             // cell value width
   localparam int ENTRY_W    = 2 * COORD_W;   // stack entry: {y, x}
   localparam int CAP_W      = 7;             // capacity register width
   localparam int OPCODE_W   = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE_CELL = 3'd0,
      OP_PUSH       = 3'd1,
      OP_PULL       = 3'd2,
      OP_PEEK       = 3'd3,
      OP_PUSH_NBRS  = 3'd4,
      OP_DRAIN_MIN  = 3'd5
   } opcode_type;

   // neighbor visit order
   localparam logic [1:0] NB_WEST  = 2'd0;
   localparam logic [1:0] NB_NORTH = 2'd1;
   localparam logic [1:0] NB_EAST  = 2'd2;
   localparam logic [1:0] NB_SOUTH = 2'd3;
   localparam logic [2:0] NB_COUNT = 3'd4;

endpackage

// ===== hw/rtl/maze_cell_stack_min_finder_unit.sv =====
`timescale 1ns / 1ps
// Top level: maze cell stack with minimum finder (sequencer, stack pointer, two RAMs).
// Depends on mcsmf_pkg and mcsmf_ram.
//
// Channel   Ports                                         Handshake
// -------   -------------------------------------------   ------------------------------
// request   req_opcode, req_pos_x, req_pos_y,             word taken when start && !busy
//           req_cell_value
// result    rsp_top_x, rsp_top_y, rsp_top_value,          word valid for one cycle while
//           rsp_min_value, rsp_is_empty, rsp_is_full,     rsp_valid is high
//           rsp_underflow, rsp_push_dropped
// csr       csr_write_en, csr_write_data                  stack_capacity written when
//                                                          csr_write_en is high
//
// A new word is taken only once the result strobe of the previous one is shown. The
// stack and maze RAMs are read one entry per cycle, so drain cost is set by the walk of
// the stack RAM read port. After reset the maze RAM is cleared one entry per cycle and
// busy stays high until every maze entry is zero. Results cannot be stalled.
module maze_cell_stack_min_finder_unit #(
   parameter int MAZE_SIDE   = mcsmf_pkg::MAZE_SIDE_DEFAULT,
   parameter int STACK_DEPTH = mcsmf_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                start,
   output logic                                busy,
   input  logic [mcsmf_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [mcsmf_pkg::COORD_W-1:0]       req_pos_x,
   input  logic [mcsmf_pkg::COORD_W-1:0]       req_pos_y,
   input  logic [mcsmf_pkg::VALUE_W-1:0]       req_cell_value,
   // result
   output logic                                rsp_valid,
   output logic [mcsmf_pkg::COORD_W-1:0]       rsp_top_x,
   output logic [mcsmf_pkg::COORD_W-1:0]       rsp_top_y,
   output logic [mcsmf_pkg::VALUE_W-1:0]       rsp_top_value,
   output logic [mcsmf_pkg::VALUE_W-1:0]       rsp_min_value,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   output logic                                rsp_underflow,
   output logic                                rsp_push_dropped,
   // configuration
   input  logic                                csr_write_en,
   input  logic [mcsmf_pkg::CAP_W-1:0]         csr_write_data
);

   localparam int COORD_W    = mcsmf_pkg::COORD_W;
   localparam int VALUE_W    = mcsmf_pkg::VALUE_W;
   localparam int ENTRY_W    = mcsmf_pkg::ENTRY_W;
   localparam int CAP_W      = mcsmf_pkg::CAP_W;
   localparam int MAZE_CELLS = MAZE_SIDE * MAZE_SIDE;
   localparam int MAW        = $clog2(MAZE_CELLS);        // maze address width
   localparam int SAW        = $clog2(STACK_DEPTH);       // stack address width
   localparam int CW         = $clog2(STACK_DEPTH + 1);   // stack count width
   localparam int CMPW       = (CW > CAP_W) ? CW : CAP_W;
   // coordinates at or beyond this bound are outside the maze
   localparam int LIMIT      = (MAZE_SIDE < mcsmf_pkg::COORD_SPAN) ?
                               MAZE_SIDE : mcsmf_pkg::COORD_SPAN;
   localparam logic [COORD_W:0]  LIMIT_C    = (COORD_W + 1)'(LIMIT);
   localparam logic [MAW-1:0]    LAST_CELL  = MAW'(MAZE_CELLS - 1);
   localparam logic [MAW-1:0]    SIDE_C     = MAW'(MAZE_SIDE);
   localparam logic [CW-1:0]     DEPTH_C    = CW'(STACK_DEPTH);

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,   // zeroing the maze after reset
      ST_IDLE   = 5'b00010,
      ST_NBRS   = 5'b00100,   // neighbor reads and pushes
      ST_STREAM = 5'b01000,   // stack read -> maze read -> compare pipeline
      ST_DONE   = 5'b10000    // capture flags, fire the result strobe
   } state_type;

   function automatic logic in_maze(input logic [COORD_W-1:0] px,
                                    input logic [COORD_W-1:0] py);
      return ({1'b0, px} < LIMIT_C) && ({1'b0, py} < LIMIT_C);
   endfunction

   // only meaningful for in-maze coordinates
   function automatic logic [MAW-1:0] maze_addr(input logic [COORD_W-1:0] px,
                                                input logic [COORD_W-1:0] py);
      return MAW'(py) * SIDE_C + MAW'(px);
   endfunction

   // ---------------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------------
   state_type                    state_ff, state_in;
   mcsmf_pkg::opcode_type        op_ff, op_in;
   logic [COORD_W-1:0]           x_ff, x_in;
   logic [COORD_W-1:0]           y_ff, y_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CAP_W-1:0]             cap_ff, cap_in;
   logic [MAW-1:0]               clr_addr_ff, clr_addr_in;

   // neighbor walk
   logic [2:0]                   nb_idx_ff, nb_idx_in;
   logic                         nb_pend_ff, nb_pend_in;
   logic [COORD_W-1:0]           nb_x_ff, nb_x_in;
   logic [COORD_W-1:0]           nb_y_ff, nb_y_in;

   // stack walk (pull, peek, drain)
   logic [CW-1:0]                ptr_ff, ptr_in;       // next read is ptr - 1
   logic [CW-1:0]                left_ff, left_in;     // entries still to read
   logic                         first_ff, first_in;
   logic                         s1_vld_ff, s1_vld_in;
   logic                         s1_first_ff, s1_first_in;
   logic                         s2_vld_ff, s2_vld_in;
   logic                         s2_first_ff, s2_first_in;
   logic                         s2_inm_ff, s2_inm_in;
   logic [COORD_W-1:0]           s2_x_ff, s2_x_in;
   logic [COORD_W-1:0]           s2_y_ff, s2_y_in;

   // result word
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]           res_tx_ff, res_tx_in;
   logic [COORD_W-1:0]           res_ty_ff, res_ty_in;
   logic [VALUE_W-1:0]           res_tv_ff, res_tv_in;
   logic [VALUE_W-1:0]           res_mv_ff, res_mv_in;
   logic                         res_empty_ff, res_empty_in;
   logic                         res_full_ff, res_full_in;
   logic                         res_under_ff, res_under_in;
   logic                         res_drop_ff, res_drop_in;

   // RAM ports
   logic                         maze_we, maze_re;
   logic [MAW-1:0]               maze_wa, maze_ra;
   logic [VALUE_W-1:0]           maze_wd, maze_rd;
   logic                         stk_we, stk_re;
   logic [SAW-1:0]               stk_wa, stk_ra;
   logic [ENTRY_W-1:0]           stk_wd, stk_rd;

   logic                         stack_full;

   // full: count at or above min(capacity, depth)
   assign stack_full = (CMPW'(count_ff) >= CMPW'(cap_ff)) || (count_ff == DEPTH_C);
   assign busy       = (state_ff != ST_IDLE);

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      mcsmf_pkg::opcode_type req_op;
      logic [COORD_W-1:0]    nx;
      logic [COORD_W-1:0]    ny;
      logic                  nb_ok;
      logic [VALUE_W-1:0]    v;
      logic [COORD_W-1:0]    px;
      logic [COORD_W-1:0]    py;
      logic [CW-1:0]         ptr_dec;

      req_op  = mcsmf_pkg::opcode_type'(req_opcode);
      nx      = x_ff;
      ny      = y_ff;
      nb_ok   = 1'b0;
      v       = '0;
      px      = stk_rd[COORD_W-1:0];
      py      = stk_rd[ENTRY_W-1:COORD_W];
      ptr_dec = ptr_ff - CW'(1);

      state_in     = state_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      count_in     = count_ff;
      cap_in       = csr_write_en ? csr_write_data : cap_ff;
      clr_addr_in  = clr_addr_ff;
      nb_idx_in    = nb_idx_ff;
      nb_pend_in   = nb_pend_ff;
      nb_x_in      = nb_x_ff;
      nb_y_in      = nb_y_ff;
      ptr_in       = ptr_ff;
      left_in      = left_ff;
      first_in     = first_ff;
      s1_vld_in    = s1_vld_ff;
      s1_first_in  = s1_first_ff;
      s2_vld_in    = s2_vld_ff;
      s2_first_in  = s2_first_ff;
      s2_inm_in    = s2_inm_ff;
      s2_x_in      = s2_x_ff;
      s2_y_in      = s2_y_ff;
      rsp_valid_in = 1'b0;
      res_tx_in    = res_tx_ff;
      res_ty_in    = res_ty_ff;
      res_tv_in    = res_tv_ff;
      res_mv_in    = res_mv_ff;
      res_empty_in = res_empty_ff;
      res_full_in  = res_full_ff;
      res_under_in = res_under_ff;
      res_drop_in  = res_drop_ff;

      maze_we = 1'b0;
      maze_wa = '0;
      maze_wd = '0;
      maze_re = 1'b0;
      maze_ra = '0;
      stk_we  = 1'b0;
      stk_wa  = count_ff[SAW-1:0];
      stk_wd  = '0;
      stk_re  = 1'b0;
      stk_ra  = ptr_dec[SAW-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            maze_we     = 1'b1;
            maze_wa     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + MAW'(1);
            if (clr_addr_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (start) begin
               op_in        = req_op;
               x_in         = req_pos_x;
               y_in         = req_pos_y;
               res_tx_in    = '0;
               res_ty_in    = '0;
               res_tv_in    = '0;
               res_mv_in    = '0;
               res_under_in = 1'b0;
               res_drop_in  = 1'b0;
               state_in     = ST_DONE;
               unique case (req_op)
                  mcsmf_pkg::OP_WRITE_CELL: begin
                     // out-of-maze writes are ignored
                     if (in_maze(req_pos_x, req_pos_y)) begin
                        maze_we = 1'b1;
                        maze_wa = maze_addr(req_pos_x, req_pos_y);
                        maze_wd = req_cell_value;
                     end
                  end
                  mcsmf_pkg::OP_PUSH: begin
                     // plain push keeps the coordinates even outside the maze
                     if (stack_full) begin
                        res_drop_in = 1'b1;
                     end else begin
                        stk_we   = 1'b1;
                        stk_wd   = {req_pos_y, req_pos_x};
                        count_in = count_ff + CW'(1);
                     end
                  end
                  mcsmf_pkg::OP_PULL,
                  mcsmf_pkg::OP_PEEK,
                  mcsmf_pkg::OP_DRAIN_MIN: begin
                     if (count_ff == '0) begin
                        res_under_in = 1'b1;
                     end else begin
                        ptr_in   = count_ff;
                        first_in = 1'b1;
                        state_in = ST_STREAM;
                        if (req_op == mcsmf_pkg::OP_DRAIN_MIN) begin
                           left_in  = count_ff;
                           count_in = '0;
                        end else begin
                           left_in  = CW'(1);
                           if (req_op == mcsmf_pkg::OP_PULL) begin
                              count_in = count_ff - CW'(1);
                           end
                        end
                     end
                  end
                  mcsmf_pkg::OP_PUSH_NBRS: begin
                     nb_idx_in  = '0;
                     nb_pend_in = 1'b0;
                     state_in   = ST_NBRS;
                  end
                  default: begin
                     // unused opcodes only report flags
                  end
               endcase
            end
         end

         ST_NBRS: begin
            // check: value read last cycle, push when nonzero (a full stack flags a drop)
            if (nb_pend_ff && (maze_rd != '0)) begin
               if (stack_full) begin
                  res_drop_in = 1'b1;
               end else begin
                  stk_we   = 1'b1;
                  stk_wd   = {nb_y_ff, nb_x_ff};
                  count_in = count_ff + CW'(1);
               end
            end
            // issue: read the next neighbor in W, N, E, S order
            nb_pend_in = 1'b0;
            if (nb_idx_ff != mcsmf_pkg::NB_COUNT) begin
               unique case (nb_idx_ff[1:0])
                  mcsmf_pkg::NB_WEST: begin
                     nx    = x_ff - COORD_W'(1);
                     nb_ok = (x_ff != '0);
                  end
                  mcsmf_pkg::NB_NORTH: begin
                     ny    = y_ff - COORD_W'(1);
                     nb_ok = (y_ff != '0);
                  end
                  mcsmf_pkg::NB_EAST: begin
                     nx    = x_ff + COORD_W'(1);
                     nb_ok = (({1'b0, x_ff} + (COORD_W + 1)'(1)) < LIMIT_C);
                  end
                  mcsmf_pkg::NB_SOUTH: begin
                     ny    = y_ff + COORD_W'(1);
                     nb_ok = (({1'b0, y_ff} + (COORD_W + 1)'(1)) < LIMIT_C);
                  end
                  default: nb_ok = 1'b0;
               endcase
               nb_ok      = nb_ok && in_maze(nx, ny);
               maze_re    = nb_ok;
               maze_ra    = maze_addr(nx, ny);
               nb_pend_in = nb_ok;
               nb_x_in    = nx;
               nb_y_in    = ny;
               nb_idx_in  = nb_idx_ff + 3'd1;
            end else if (!nb_pend_ff) begin
               state_in = ST_DONE;
            end
         end

         ST_STREAM: begin
            // stage 2: maze value back, fold into result
            if (s2_vld_ff) begin
               v = s2_inm_ff ? maze_rd : '0;
               if (op_ff == mcsmf_pkg::OP_DRAIN_MIN) begin
                  // top seeds the minimum; later nonzero values win ties
                  if (s2_first_ff || ((v != '0) && (res_mv_ff >= v))) begin
                     res_mv_in = v;
                  end
               end else begin
                  res_tx_in = s2_x_ff;
                  res_ty_in = s2_y_ff;
                  res_tv_in = v;
               end
            end
            // stage 1: stack entry back, look up its cell
            s2_vld_in   = s1_vld_ff;
            s2_first_in = s1_first_ff;
            s2_x_in     = px;
            s2_y_in     = py;
            s2_inm_in   = in_maze(px, py);
            if (s1_vld_ff && in_maze(px, py)) begin
               maze_re = 1'b1;
               maze_ra = maze_addr(px, py);
            end
            // issue: walk the stack from the top down
            s1_vld_in   = (left_ff != '0);
            s1_first_in = first_ff;
            if (left_ff != '0) begin
               stk_re   = 1'b1;
               ptr_in   = ptr_dec;
               left_in  = left_ff - CW'(1);
               first_in = 1'b0;
            end else if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            res_empty_in = (count_ff == '0);
            res_full_in  = stack_full;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         count_ff     <= '0;
         cap_ff       <= mcsmf_pkg::CAP_RESET;
         clr_addr_ff  <= '0;
         nb_idx_ff    <= '0;
         nb_pend_ff   <= 1'b0;
         left_ff      <= '0;
         first_ff     <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         clr_addr_ff  <= clr_addr_in;
         nb_idx_ff    <= nb_idx_in;
         nb_pend_ff   <= nb_pend_in;
         left_ff      <= left_in;
         first_ff     <= first_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      nb_x_ff      <= nb_x_in;
      nb_y_ff      <= nb_y_in;
      ptr_ff       <= ptr_in;
      s1_first_ff  <= s1_first_in;
      s2_first_ff  <= s2_first_in;
      s2_inm_ff    <= s2_inm_in;
      s2_x_ff      <= s2_x_in;
      s2_y_ff      <= s2_y_in;
      res_tx_ff    <= res_tx_in;
      res_ty_ff    <= res_ty_in;
      res_tv_ff    <= res_tv_in;
      res_mv_ff    <= res_mv_in;
      res_empty_ff <= res_empty_in;
      res_full_ff  <= res_full_in;
      res_under_ff <= res_under_in;
      res_drop_ff  <= res_drop_in;
   end

   // ---------------------------------------------------------------------------
   // Memories. Reads and writes of one item are sequenced, and a new item is only
   // taken once the previous one has retired, so no same-entry overlap occurs.
   // ---------------------------------------------------------------------------
   mcsmf_ram #(
      .DATA_W (VALUE_W),
      .DEPTH  (MAZE_CELLS)
   ) u_maze_ram (
      .clock   (clock),
      .wr_en   (maze_we),
      .wr_addr (maze_wa),
      .wr_data (maze_wd),
      .rd_en   (maze_re),
      .rd_addr (maze_ra),
      .rd_data (maze_rd)
   );

   mcsmf_ram #(
      .DATA_W (ENTRY_W),
      .DEPTH  (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (stk_wd),
      .rd_en   (stk_re),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   // result word
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_top_x        = res_tx_ff;
   assign rsp_top_y        = res_ty_ff;
   assign rsp_top_value    = res_tv_ff;
   assign rsp_min_value    = res_mv_ff;
   assign rsp_is_empty     = res_empty_ff;
   assign rsp_is_full      = res_full_ff;
   assign rsp_underflow    = res_under_ff;
   assign rsp_push_dropped = res_drop_ff;

endmodule

// ===== hw/rtl/mcsmf_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// Depends on mcsmf_pkg for default sizes.
module mcsmf_ram #(
   parameter int DATA_W = mcsmf_pkg::VALUE_W,
   parameter int DEPTH  = mcsmf_pkg::MAZE_SIDE_DEFAULT * mcsmf_pkg::MAZE_SIDE_DEFAULT,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mcsmf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for maze_cell_stack_min_finder_unit, bound to the top level.
// Depends on mcsmf_pkg.
module mcsmf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [mcsmf_pkg::VALUE_W-1:0]  rsp_top_value,
   input logic [mcsmf_pkg::VALUE_W-1:0]  rsp_min_value,
   input logic                           rsp_is_empty,
   input logic                           rsp_underflow,
   input logic                           rsp_push_dropped
);

   // maze clearing keeps the block busy right after reset
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_underflow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_underflow) |->
         (rsp_is_empty && (rsp_min_value == '0) && (rsp_top_value == '0) &&
          !rsp_push_dropped))
      else $error("underflow word with non-empty stack or data");

endmodule

bind maze_cell_stack_min_finder_unit mcsmf_checker u_mcsmf_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_top_value    (rsp_top_value),
   .rsp_min_value    (rsp_min_value),
   .rsp_is_empty     (rsp_is_empty),
   .rsp_underflow    (rsp_underflow),
   .rsp_push_dropped (rsp_push_dropped)
);
